### hdl/ipd_pkg.sv
// ----------------------------------------------------------------------------
// ipd_pkg
// shared types and constants of the ir pulse distance decoder
// ----------------------------------------------------------------------------
`default_nettype none

package ipd_pkg;

    // payload widths
    localparam int TS_W      = 32;
    localparam int HALF_W    = 16;
    localparam int BITS_W    = 6;
    localparam int STEP_W    = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 16;

    // reset value of the timing unit
    localparam logic [STEP_W-1:0] TIME_STEP_RESET = 16'd500;

    // pulse lengths in timing units
    localparam int UNITS_START_MARK  = 18;
    localparam int UNITS_START_SPACE = 9;
    localparam int UNITS_REPEAT_A    = 4;
    localparam int UNITS_REPEAT_B    = 5;
    localparam int UNITS_SHORT       = 1;
    localparam int UNITS_LONG_A      = 3;
    localparam int UNITS_LONG_B      = 4;
    localparam int FRAME_BITS        = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP       = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPORT_FAILURES = 1'b1;

    // result kinds
    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_FRAME  = 2'd1,
        EV_REPEAT = 2'd2,
        EV_FAIL   = 2'd3
    } t_event_kind;

    // decoder phase
    typedef enum logic [5:0] {
        PH_INIT  = 6'b000001,
        PH_IDLE  = 6'b000010,
        PH_START = 6'b000100,
        PH_MARK  = 6'b001000,
        PH_SPACE = 6'b010000,
        PH_DONE  = 6'b100000
    } t_phase;

    // sequencer state
    typedef enum logic [2:0] {
        SQ_IDLE   = 3'b001,
        SQ_DIV    = 3'b010,
        SQ_COMMIT = 3'b100
    } t_seq;

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

`default_nettype wire

### hdl/ipd_if.sv
// ----------------------------------------------------------------------------
// ipd_if
// valid/ready channels for edge requests and decode results
// ----------------------------------------------------------------------------
`default_nettype none

interface ipd_in_if
    import ipd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              level;
    logic [TS_W-1:0]   timestamp;

    modport source (output valid, output level, output timestamp, input ready);
    modport sink   (input valid, input level, input timestamp, output ready);
endinterface

interface ipd_out_if
    import ipd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [1:0]        event_kind;
    logic [HALF_W-1:0] word_low;
    logic [HALF_W-1:0] word_high;
    logic [BITS_W-1:0] bit_count;
    logic [TS_W-1:0]   event_time;

    modport source (output valid, output event_kind, output word_low, output word_high,
                    output bit_count, output event_time, input ready);
    modport sink   (input valid, input event_kind, input word_low, input word_high,
                    input bit_count, input event_time, output ready);
endinterface

`default_nettype wire

### hdl/ir_pulse_distance_decoder_top.sv
// ----------------------------------------------------------------------------
// ir_pulse_distance_decoder_top
// decodes pulse distance remote frames from timestamped line edges
// ----------------------------------------------------------------------------
// usage:
//   i_in carries one request per line edge: the level after the edge and the
//   free running timestamp. o_out carries at most one result per edge: frame,
//   repeat or failure, with the words, the bit count and the edge timestamp.
//   i_cfg_we/i_cfg_idx/i_cfg_data write time_step (index 0) and
//   report_failures (index 1); write them only while the block is idle.
// timing:
//   each edge runs through the bit serial rounding divider, which produces
//   one quotient bit a cycle; i_in.ready is high only between edges.
//   the divider's done strobe moves the sequencer to its commit state,
//   which writes a result to the output register.
// reset:
//   synchronous active low; the first edge after reset only marks the time.
// stall:
//   a held result stays in the output register; the next edge is still
//   accepted and runs, and if it has a result, its update waits until the output is free.
// ----------------------------------------------------------------------------
`default_nettype none

module ir_pulse_distance_decoder_top
    import ipd_pkg::*;
#(
    parameter int TIMER_BITS = 20
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    ipd_in_if.sink                    i_in,
    ipd_out_if.source                 o_out,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data
);

    localparam int NUM_W = ((TIMER_BITS > STEP_W) ? TIMER_BITS : STEP_W) + 1;

    // configuration
    logic [STEP_W-1:0]     r_time_step;
    logic                  r_report;

    // sequencer and decoder state
    t_seq                  r_seq, n_seq;
    t_phase                r_phase, n_phase;
    logic [TIMER_BITS-1:0] r_prev_edge;
    logic [HALF_W-1:0]     r_low, n_low;
    logic [HALF_W-1:0]     r_high, n_high;
    logic [BITS_W-1:0]     r_bits, n_bits;
    logic                  r_prev_failed, n_prev_failed;
    logic                  r_level;
    logic [TS_W-1:0]       r_ts;

    // output register
    logic                  r_out_valid;
    t_event_kind           r_out_kind;
    logic [HALF_W-1:0]     r_out_low;
    logic [HALF_W-1:0]     r_out_high;
    logic [BITS_W-1:0]     r_out_bits;
    logic [TS_W-1:0]       r_out_time;

    logic                  w_accept;
    logic                  w_commit;
    logic [STEP_W-1:0]     w_step;
    logic [TIMER_BITS-1:0] w_delta;
    logic [NUM_W-1:0]      w_num;
    t_div_status           w_div_st;
    logic [NUM_W-1:0]      w_units;
    logic                  d_emit;
    logic                  d_fail;
    t_event_kind           d_kind;

    assign i_in.ready = (r_seq == SQ_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;

    // rounding numerator: interval modulo the timer plus half a unit
    assign w_step  = (r_time_step == '0) ? STEP_W'(1) : r_time_step;
    assign w_delta = i_in.timestamp[TIMER_BITS-1:0] - r_prev_edge;
    assign w_num   = NUM_W'(w_delta) + NUM_W'(w_step[STEP_W-1:1]);

    ipd_div #(
        .NUM_W (NUM_W),
        .DEN_W (STEP_W)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_accept),
        .i_num    (w_num),
        .i_den    (w_step),
        .o_status (w_div_st),
        .o_quot   (w_units)
    );

    // decoder step on the rounded interval
    always_comb begin
        n_phase       = r_phase;
        n_low         = r_low;
        n_high        = r_high;
        n_bits        = r_bits;
        n_prev_failed = r_prev_failed;
        d_emit        = 1'b0;
        d_fail        = 1'b0;
        d_kind        = EV_NONE;
        unique case (r_phase)
            PH_INIT: begin
                n_phase       = PH_IDLE;
                n_prev_failed = 1'b1;
            end
            PH_IDLE: begin
                if (w_units == NUM_W'(UNITS_START_MARK) && r_level) begin
                    n_phase = PH_START;
                end
            end
            PH_START: begin
                if (w_units == NUM_W'(UNITS_START_SPACE) && !r_level) begin
                    n_phase = PH_MARK;
                    n_bits  = '0;
                    n_low   = '0;
                    n_high  = '0;
                end else if ((w_units == NUM_W'(UNITS_REPEAT_A) ||
                              w_units == NUM_W'(UNITS_REPEAT_B)) && !r_level) begin
                    n_phase = PH_IDLE;
                    if (!r_prev_failed) begin
                        d_emit = 1'b1;
                        d_kind = EV_REPEAT;
                    end
                end else begin
                    d_fail = 1'b1;
                end
            end
            PH_MARK: begin
                if (w_units == NUM_W'(UNITS_SHORT) && r_level) begin
                    n_phase = PH_SPACE;
                end else begin
                    d_fail = 1'b1;
                end
            end
            PH_SPACE: begin
                if ((w_units == NUM_W'(UNITS_SHORT) || w_units == NUM_W'(UNITS_LONG_A) ||
                     w_units == NUM_W'(UNITS_LONG_B)) && !r_level) begin
                    // long space is a one bit
                    if (w_units != NUM_W'(UNITS_SHORT)) begin
                        if (!r_bits[4]) begin
                            n_low = r_low | (HALF_W'(1) << r_bits[3:0]);
                        end else begin
                            n_high = r_high | (HALF_W'(1) << r_bits[3:0]);
                        end
                    end
                    n_bits  = r_bits + 1'b1;
                    n_phase = PH_MARK;
                    if (n_bits >= BITS_W'(FRAME_BITS)) begin
                        n_phase       = PH_DONE;
                        n_prev_failed = 1'b0;
                        d_emit        = 1'b1;
                        d_kind        = EV_FRAME;
                    end
                end else begin
                    d_fail = 1'b1;
                end
            end
            PH_DONE: begin
                n_phase = PH_IDLE;
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
        // any unexpected pulse drops the frame
        if (d_fail) begin
            n_phase       = PH_IDLE;
            n_prev_failed = 1'b1;
            if (r_report) begin
                d_emit = 1'b1;
                d_kind = EV_FAIL;
            end
        end
    end

    // commit when no result is due or the output register is free
    assign w_commit = (r_seq == SQ_COMMIT) &&
                      (!d_emit || !r_out_valid || o_out.ready);

    // sequencer
    always_comb begin
        n_seq = r_seq;
        unique case (r_seq)
            SQ_IDLE:   if (w_accept) n_seq = SQ_DIV;
            SQ_DIV:    if (w_div_st.done) n_seq = SQ_COMMIT;
            SQ_COMMIT: if (w_commit) n_seq = SQ_IDLE;
            default:   n_seq = SQ_IDLE;
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step <= TIME_STEP_RESET;
            r_report    <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TIME_STEP:       r_time_step <= i_cfg_data[STEP_W-1:0];
                CFG_REPORT_FAILURES: r_report    <= i_cfg_data[0];
            endcase
        end
    end

    // sequencer and decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq         <= SQ_IDLE;
            r_phase       <= PH_INIT;
            r_prev_edge   <= '0;
            r_low         <= '0;
            r_high        <= '0;
            r_bits        <= '0;
            r_prev_failed <= 1'b1;
        end else begin
            r_seq <= n_seq;
            if (w_accept) begin
                r_prev_edge <= i_in.timestamp[TIMER_BITS-1:0];
            end
            if (w_commit) begin
                r_phase       <= n_phase;
                r_low         <= n_low;
                r_high        <= n_high;
                r_bits        <= n_bits;
                r_prev_failed <= n_prev_failed;
            end
        end
    end

    // latched request fields
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_level <= i_in.level;
            r_ts    <= i_in.timestamp;
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit && d_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (w_commit && d_emit) begin
            r_out_kind <= d_kind;
            r_out_low  <= n_low;
            r_out_high <= n_high;
            r_out_bits <= n_bits;
            r_out_time <= r_ts;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.event_kind = r_out_kind;
    assign o_out.word_low   = r_out_low;
    assign o_out.word_high  = r_out_high;
    assign o_out.bit_count  = r_out_bits;
    assign o_out.event_time = r_out_time;

`ifndef SYNTHESIS
    // an accepted edge always starts the divider
    a_accept_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> w_div_st.busy)
        else $error("divider not started after edge request");

    // the divider only finishes while the sequencer waits for it
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_st.done |-> (r_seq == SQ_DIV))
        else $error("divider done outside of divide state");

    // a shown result always carries a real kind
    a_kind_real: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.event_kind != EV_NONE))
        else $error("result without event kind");

    // the bit count never passes a full frame
    a_bits_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bits <= BITS_W'(FRAME_BITS))
        else $error("bit count beyond frame length");
`endif

endmodule

`default_nettype wire

### hdl/ipd_div.sv
// ----------------------------------------------------------------------------
// ipd_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module ipd_div
    import ipd_pkg::*;
#(
    parameter int NUM_W = 21,
    parameter int DEN_W = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output t_div_status           o_status,
    output logic      [NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DEN_W:0]   w_trial;
    logic [DEN_W:0]   w_diff;

    // shift in the next numerator bit and try the subtract
    assign w_trial = {r_rem, r_quo[NUM_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            if (!w_diff[DEN_W]) begin
                r_rem <= w_diff[DEN_W-1:0];
                r_quo <= {r_quo[NUM_W-2:0], 1'b1};
            end else begin
                r_rem <= w_trial[DEN_W-1:0];
                r_quo <= {r_quo[NUM_W-2:0], 1'b0};
            end
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quot        = r_quo;

endmodule

`default_nettype wire

### test/tb_ir_pulse_distance_decoder_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ir_pulse_distance_decoder_top
// self-checking bench for the ir pulse distance decoder
// ----------------------------------------------------------------------------
// a short table of hand-built edges covers the first edge, start marks,
// suppressed repeats, bad levels, bad pulse lengths and timer wrap. random
// phases follow under several timing units, from 0 and 1 up to 65535, with
// failure reporting on and off: mostly clean frames and repeats, frames and
// repeats broken at a random edge, plus stray edges. every accepted edge
// request runs through a local decoder model and each result is checked in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_ir_pulse_distance_decoder_top;
    import ipd_pkg::*;

    localparam int TIMER_BITS     = 20;
    localparam int DECODE_LATENCY = TIMER_BITS + 4;
    localparam int HOLD_CYCLES    = 1000;
    localparam int NUM_PHASES     = 8;

    typedef struct packed {
        t_event_kind       kind;
        logic [HALF_W-1:0] word_low;
        logic [HALF_W-1:0] word_high;
        logic [BITS_W-1:0] bit_count;
        logic [TS_W-1:0]   event_time;
    } t_decode_result;

    // one hand-built edge: level, ticks since the last edge, optional fixed result
    typedef struct packed {
        logic              level;
        logic [TS_W-1:0]   gap;
        logic              fixed;
        t_event_kind       kind;
        logic [HALF_W-1:0] word_low;
        logic [BITS_W-1:0] bit_count;
    } t_edge_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    ipd_in_if  edge_if ();
    ipd_out_if result_if ();

    ir_pulse_distance_decoder_top #(
        .TIMER_BITS (TIMER_BITS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (edge_if),
        .o_out      (result_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // decoder model state and its copy of the registers
    t_phase                dec_phase;
    logic [TIMER_BITS-1:0] last_edge_time;
    logic [HALF_W-1:0]     acc_low;
    logic [HALF_W-1:0]     acc_high;
    logic [BITS_W-1:0]     acc_bits;
    logic                  last_frame_failed;
    logic [STEP_W-1:0]     cfg_time_step;
    logic                  cfg_report_failures;

    t_decode_result pending_results[$];
    int             error_count;
    int             edges_sent;
    int             frames_seen;
    int             repeats_seen;
    int             failures_seen;
    logic [TS_W-1:0] ts_now;
    bit             steady;
    bit             hold_armed;

    // directed edges, starting just below the 32 bit timestamp wrap, unit 500
    t_edge_row directed_rows [22] = '{
        '{1'b0, 32'd0,       1'b1, EV_NONE, 16'd0, 6'd0},  // first edge after reset
        '{1'b1, 32'd9000,    1'b0, EV_NONE, 16'd0, 6'd0},  // start mark
        '{1'b0, 32'd2000,    1'b0, EV_NONE, 16'd0, 6'd0},  // repeat, no good frame yet
        '{1'b1, 32'd9249,    1'b0, EV_NONE, 16'd0, 6'd0},  // start mark, rounds down
        '{1'b1, 32'd4500,    1'b1, EV_FAIL, 16'd0, 6'd0},  // start space with high level
        '{1'b1, 32'd8750,    1'b0, EV_NONE, 16'd0, 6'd0},  // start mark, rounds up
        '{1'b0, 32'd4500,    1'b0, EV_NONE, 16'd0, 6'd0},  // frame start
        '{1'b1, 32'd500,     1'b0, EV_NONE, 16'd0, 6'd0},
        '{1'b0, 32'd1500,    1'b0, EV_NONE, 16'd0, 6'd0},  // one, 3 units
        '{1'b1, 32'd749,     1'b0, EV_NONE, 16'd0, 6'd0},
        '{1'b0, 32'd1749,    1'b0, EV_NONE, 16'd0, 6'd0},  // one, rounds to 3
        '{1'b1, 32'd500,     1'b0, EV_NONE, 16'd0, 6'd0},
        '{1'b0, 32'd2000,    1'b0, EV_NONE, 16'd0, 6'd0},  // one, 4 units
        '{1'b1, 32'd500,     1'b0, EV_NONE, 16'd0, 6'd0},
        '{1'b0, 32'd500,     1'b0, EV_NONE, 16'd0, 6'd0},  // zero
        '{1'b1, 32'd1000,    1'b1, EV_FAIL, 16'd7, 6'd4},  // 2 unit mark
        '{1'b1, 32'd1057576, 1'b0, EV_NONE, 16'd0, 6'd0},  // start mark across timer wrap
        '{1'b0, 32'd2500,    1'b0, EV_NONE, 16'd0, 6'd0},  // repeat after failure
        '{1'b1, 32'd1048575, 1'b0, EV_NONE, 16'd0, 6'd0},  // longest interval
        '{1'b0, 32'd0,       1'b0, EV_NONE, 16'd0, 6'd0},  // zero interval
        '{1'b1, 32'd9000,    1'b0, EV_NONE, 16'd0, 6'd0},
        '{1'b0, 32'd3000,    1'b1, EV_FAIL, 16'd7, 6'd4}   // 6 unit start space
    };

    // clock
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= 30) begin
            $display("mismatch at %0t: %s", $realtime, what);
        end
    endtask

    task automatic reset_decoder_model();
        cfg_time_step       = TIME_STEP_RESET;
        cfg_report_failures = 1'b1;
        dec_phase           = PH_INIT;
        last_edge_time      = '0;
        acc_low             = '0;
        acc_high            = '0;
        acc_bits            = '0;
        last_frame_failed   = 1'b1;
    endtask

    // advance the decoder model by one edge; returns 1 when a result is due
    function automatic bit decode_edge(input logic lvl, input logic [TS_W-1:0] ts,
                                       output t_decode_result res);
        logic [TIMER_BITS-1:0] now;
        logic [TIMER_BITS-1:0] delta;
        int unsigned           step;
        int unsigned           units;
        logic [4:0]            pos;
        t_event_kind           kind;
        bit                    hit;
        bit                    bad;

        now   = ts[TIMER_BITS-1:0];
        delta = now - last_edge_time;
        step  = (cfg_time_step == 0) ? 1 : cfg_time_step;
        units = (32'(delta) + step / 2) / step;
        last_edge_time = now;
        kind = EV_NONE;
        hit  = 1'b0;
        bad  = 1'b0;

        case (dec_phase)
            PH_INIT: begin
                dec_phase         = PH_IDLE;
                last_frame_failed = 1'b1;
            end
            PH_IDLE: begin
                if (units == UNITS_START_MARK && lvl) begin
                    dec_phase = PH_START;
                end
            end
            PH_START: begin
                if (units == UNITS_START_SPACE && !lvl) begin
                    dec_phase = PH_MARK;
                    acc_bits  = '0;
                    acc_low   = '0;
                    acc_high  = '0;
                end else if ((units == UNITS_REPEAT_A || units == UNITS_REPEAT_B) && !lvl) begin
                    dec_phase = PH_IDLE;
                    kind      = EV_REPEAT;
                    hit       = !last_frame_failed;
                end else begin
                    bad = 1'b1;
                end
            end
            PH_MARK: begin
                if (units == UNITS_SHORT && lvl) begin
                    dec_phase = PH_SPACE;
                end else begin
                    bad = 1'b1;
                end
            end
            PH_SPACE: begin
                if ((units == UNITS_SHORT || units == UNITS_LONG_A || units == UNITS_LONG_B)
                    && !lvl) begin
                    if (units != UNITS_SHORT) begin
                        pos = acc_bits[4:0];
                        if (pos < 16) begin
                            acc_low[pos[3:0]] = 1'b1;
                        end else begin
                            acc_high[pos[3:0]] = 1'b1;
                        end
                    end
                    acc_bits  = acc_bits + 1'b1;
                    dec_phase = PH_MARK;
                    if (acc_bits >= FRAME_BITS) begin
                        dec_phase         = PH_DONE;
                        last_frame_failed = 1'b0;
                        kind              = EV_FRAME;
                        hit               = 1'b1;
                    end
                end else begin
                    bad = 1'b1;
                end
            end
            default: begin
                dec_phase = PH_IDLE;
            end
        endcase

        // any broken pattern drops back to idle
        if (bad) begin
            dec_phase         = PH_IDLE;
            last_frame_failed = 1'b1;
            kind              = EV_FAIL;
            hit               = cfg_report_failures;
        end

        res = '{kind, acc_low, acc_high, acc_bits, ts};
        return hit;
    endfunction

    // offer one edge request, wait for it to be taken, then predict
    task automatic send_edge(input logic lvl, input logic [TS_W-1:0] ts, input bit fixed,
                             input t_decode_result fixed_res);
        t_decode_result res;
        bit             hit;

        while (!steady && $urandom_range(0, 99) < 22) begin
            edge_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        edge_if.valid     <= 1'b1;
        edge_if.level     <= lvl;
        edge_if.timestamp <= ts;
        do @(posedge i_clk); while (!edge_if.ready);
        hit = decode_edge(lvl, ts, res);
        if (fixed) begin
            if (fixed_res.kind != EV_NONE) begin
                pending_results.push_back(fixed_res);
            end
        end else if (hit) begin
            pending_results.push_back(res);
        end
        edges_sent++;
    endtask

    // edge a given number of units after the last one, with rounding jitter
    task automatic send_units(input logic lvl, input int unsigned units);
        int unsigned step;
        int unsigned off;

        step = (cfg_time_step == 0) ? 1 : cfg_time_step;
        if (units == 0) begin
            off = $urandom_range(0, (step - 1) / 2);
        end else if ($urandom_range(0, 3) == 0) begin
            off = $urandom_range(0, 1) ? units * step - step / 2
                                       : units * step + step - 1 - step / 2;
        end else begin
            off = units * step + $urandom_range(0, step - 1) - step / 2;
        end
        ts_now = ts_now + off;
        send_edge(lvl, ts_now, 1'b0, '0);
    endtask

    // frame or repeat code, optionally broken at one edge and cut off there
    task automatic send_pattern(input bit as_repeat, input int break_at);
        logic        lvl;
        int unsigned units;
        int          last;

        last = as_repeat ? 1 : 2 * FRAME_BITS + 1;
        for (int pos = 0; pos <= last; pos++) begin
            if (pos == 0) begin
                lvl   = 1'b1;
                units = UNITS_START_MARK;
            end else if (pos == 1) begin
                lvl   = 1'b0;
                units = !as_repeat ? UNITS_START_SPACE
                      : ($urandom_range(0, 1) ? UNITS_REPEAT_A : UNITS_REPEAT_B);
            end else if (pos % 2 == 0) begin
                lvl   = 1'b1;
                units = UNITS_SHORT;
            end else begin
                lvl = 1'b0;
                case ($urandom_range(0, 2))
                    0: units = UNITS_SHORT;
                    1: units = UNITS_LONG_A;
                    default: units = UNITS_LONG_B;
                endcase
            end
            if (pos == break_at) begin
                if ($urandom_range(0, 1)) begin
                    lvl = ~lvl;
                end else begin
                    units = $urandom_range(0, 20);
                end
                send_units(lvl, units);
                return;
            end
            send_units(lvl, units);
        end
        // edge after a full frame returns to idle
        if (!as_repeat) begin
            send_units(1'($urandom_range(0, 1)), $urandom_range(0, 30));
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_TIME_STEP:       cfg_time_step = data;
            CFG_REPORT_FAILURES: cfg_report_failures = data[0];
            default: ;
        endcase
    endtask

    // stop offering, let every expected result come and the last edge finish
    task automatic wait_quiet();
        edge_if.valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (2 * DECODE_LATENCY) @(posedge i_clk);
    endtask

    // result sink: random stalls, one long hold, in-order checking
    initial begin
        t_decode_result got;
        t_decode_result want;
        int             hold_left;
        bit             hold_done;

        result_if.ready = 1'b0;
        hold_left       = 0;
        hold_done       = 1'b0;
        forever begin
            @(posedge i_clk);
            if (result_if.valid && result_if.ready) begin
                got = '{t_event_kind'(result_if.event_kind), result_if.word_low,
                        result_if.word_high, result_if.bit_count, result_if.event_time};
                case (got.kind)
                    EV_FRAME:  frames_seen++;
                    EV_REPEAT: repeats_seen++;
                    EV_FAIL:   failures_seen++;
                    default: ;
                endcase
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result kind %0d time %h",
                                              got.kind, got.event_time));
                end else begin
                    want = pending_results.pop_front();
                    if (got != want) begin
                        report_mismatch($sformatf(
                            "got %0d %h %h %0d %h, want %0d %h %h %0d %h",
                            got.kind, got.word_low, got.word_high, got.bit_count,
                            got.event_time, want.kind, want.word_low, want.word_high,
                            want.bit_count, want.event_time));
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                result_if.ready <= 1'b0;
            end else if (hold_armed && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                result_if.ready <= 1'b0;
            end else begin
                result_if.ready <= steady || ($urandom_range(0, 99) >= 22);
            end
        end
    end

    // stimulus
    initial begin
        t_decode_result fixed_res;
        int             phase_end;
        int             pick;
        bit             rep;
        logic [CFG_DAT_W-1:0] step_val;
        logic                 report_val;

        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = '0;
        i_cfg_data        = '0;
        edge_if.valid     = 1'b0;
        edge_if.level     = 1'b0;
        edge_if.timestamp = '0;
        error_count       = 0;
        edges_sent        = 0;
        frames_seen       = 0;
        repeats_seen      = 0;
        failures_seen     = 0;
        steady            = 1'b0;
        hold_armed        = 1'b0;
        reset_decoder_model();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed edges under reset settings, with the long output hold
        hold_armed = 1'b1;
        ts_now     = 32'hffff_c000;
        foreach (directed_rows[r]) begin
            ts_now    = ts_now + directed_rows[r].gap;
            fixed_res = '{directed_rows[r].kind, directed_rows[r].word_low, 16'd0,
                          directed_rows[r].bit_count, ts_now};
            send_edge(directed_rows[r].level, ts_now, directed_rows[r].fixed, fixed_res);
        end

        // random phases, each under its own timing unit and failure setting
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_quiet();
            case (ph)
                0: begin step_val = 16'd500;   report_val = 1'b1; end
                1: begin step_val = 16'd1;     report_val = 1'b1; end
                2: begin step_val = 16'd65535; report_val = 1'b0; end
                3: begin step_val = 16'd0;     report_val = 1'b1; end
                default: begin
                    step_val   = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(2000, 58000))
                                                             : 16'($urandom_range(2, 1500));
                    report_val = 1'($urandom_range(0, 1));
                end
            endcase
            write_reg(CFG_TIME_STEP, step_val);
            write_reg(CFG_REPORT_FAILURES, {15'($urandom_range(0, 32767)), report_val});
            steady    = (ph == 1);
            ts_now    = $urandom;
            phase_end = edges_sent + ((ph == 0) ? 220 : (ph < 4) ? 90 : 140);
            while (edges_sent < phase_end) begin
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    send_pattern(1'b0, -1);
                    repeat ($urandom_range(0, 2)) send_pattern(1'b1, -1);
                end else if (pick < 60) begin
                    send_pattern(1'b1, -1);
                end else if (pick < 85) begin
                    rep = ($urandom_range(0, 3) == 0);
                    send_pattern(rep, $urandom_range(0, rep ? 1 : 2 * FRAME_BITS + 1));
                end else begin
                    // stray edges, some with fully random timestamps
                    repeat ($urandom_range(1, 4)) begin
                        ts_now = $urandom_range(0, 1) ? $urandom
                                                      : ts_now + $urandom_range(0, 1 << 21);
                        send_edge(1'($urandom_range(0, 1)), ts_now, 1'b0, '0);
                    end
                end
            end
        end
        steady = 1'b0;
        wait_quiet();

        $display("ran %0d edges over %0d timing setups", edges_sent, NUM_PHASES + 1);
        $display("checked %0d frames, %0d repeats, %0d failures, %0d mismatches",
                 frames_seen, repeats_seen, failures_seen, error_count);
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(5_000_000);
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire

### ir_pulse_distance_decoder_top.f
hdl/ipd_pkg.sv
hdl/ipd_if.sv
hdl/ipd_div.sv
hdl/ir_pulse_distance_decoder_top.sv
test/tb_ir_pulse_distance_decoder_top.sv
